FILE: rtl/rlp_pkg.sv
// Package with shared constants and types for the replay ledger probe.
`default_nettype none
package rlp_pkg;
    localparam int SLOT_COUNT_DEF   = 256;
    localparam int PROBE_LENGTH_DEF = 8;
    localparam logic [63:0] HASH_MULT = 64'h9E3779B97F4A7C15;
    localparam logic [7:0]  WINDOW_RESET = 8'd2;
    localparam int SUBJ_W  = 64;
    localparam int SEQ_W   = 64;
    localparam int EPOCH_W = 32;
    localparam int CNT_W   = 32;

    typedef struct packed {
        logic [SUBJ_W-1:0]  subj;
        logic [SEQ_W-1:0]   seq;
        logic [EPOCH_W-1:0] epoch;
    } t_entry;
endpackage
`default_nettype wire

FILE: rtl/rlp_hash.sv
// Iterative 64-bit multiply-add hash, 16 bits of the multiplier per cycle.
`default_nettype none
module rlp_hash (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_subject,
    input  wire logic [63:0] i_seq,
    output logic             o_done,
    output logic [63:0]      o_hash
);
    logic [63:0] r_acc, n_acc;
    logic [63:0] r_a, n_a;
    logic [2:0]  r_step, n_step;
    logic        r_busy, n_busy;
    logic [63:0] w_prod;

    // 64 x 16 partial product of the subject with one chunk of the constant.
    assign w_prod = r_a * {48'd0, rlp_pkg::HASH_MULT[16*r_step[1:0] +: 16]};

    always_comb begin
        n_acc  = r_acc;
        n_a    = r_a;
        n_step = r_step;
        n_busy = r_busy;
        o_done = 1'b0;
        if (i_start) begin
            n_acc  = i_seq;
            n_a    = i_subject;
            n_step = 3'd0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_acc  = r_acc + w_prod;
            n_a    = {r_a[47:0], 16'd0};
            n_step = r_step + 3'd1;
            if (r_step == 3'd3) begin
                n_busy = 1'b0;
                o_done = 1'b1;
            end
        end
    end

    assign o_hash = n_acc;

    always_ff @(posedge i_clk) begin
        r_acc  <= n_acc;
        r_a    <= n_a;
        r_step <= n_step;
        if (!i_rst_n) r_busy <= 1'b0;
        else          r_busy <= n_busy;
    end
endmodule
`default_nettype wire

FILE: rtl/replay_ledger_probe_unit.sv
// Top level of the replay ledger probe: sequencer, table memory and counters.
//
// Usage: one request beat enters on the s_axis channel (tdata holds subject,
// sequence number and epoch). The block hashes it, probes up to PROBE_LENGTH
// slots for a live match through the table and, if none matches, probes
// again for an empty or stale slot, else evicts the home slot, and writes
// the entry. One result beat leaves on m_axis. Each memory read has an
// address state (S_RD) and a check of the registered data (S_CHK); a match
// ends the request early, as does an empty or stale slot in the second pass.
// s_axis_tready is high only while the sequencer is idle and no result is
// waiting; a stalled receiver holds the result register and the block.
// After reset a clearing pass writes zero into every slot while no request
// is taken; the window register may be written meanwhile.
// The window register resets to 2 and is written by i_cfg_we/i_cfg_wdata.
`default_nettype none
module replay_ledger_probe_unit #(
    parameter int SLOT_COUNT   = rlp_pkg::SLOT_COUNT_DEF,
    parameter int PROBE_LENGTH = rlp_pkg::PROBE_LENGTH_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_we,
    input  wire logic [7:0]   i_cfg_wdata,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // tdata: subject[63:0], sequence_number[127:64], now_epoch[159:128]
    input  wire logic [159:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // tdata: verdict[0], evicted[1], slot_written[9:2], accepted_total[41:10],
    // rejected_total[73:42], evicted_total[105:74], zero fill[111:106]
    output logic [111:0]      m_axis_tdata
);
    localparam int IW = $clog2(SLOT_COUNT);
    localparam int PW = $clog2(PROBE_LENGTH + 1);

    typedef enum logic [7:0] {
        S_CLEAR = 8'b00000001,
        S_IDLE  = 8'b00000010,
        S_HASH  = 8'b00000100,
        S_RD    = 8'b00001000,
        S_CHK   = 8'b00010000,
        S_WR    = 8'b00100000,
        S_OUT   = 8'b01000000
    } t_state;

    t_state r_state, n_state;
    logic [7:0]   r_win;
    logic [63:0]  r_subj, r_seq;
    logic [31:0]  r_now;
    logic [IW-1:0] r_home, r_slot, r_clr;
    logic [PW-1:0] r_i;
    logic          r_pass;   // 0 match search, 1 free slot search
    logic          r_verdict, r_evict;
    logic [31:0]   r_acc_cnt, r_rej_cnt, r_ev_cnt;
    logic          r_out_v;
    rlp_pkg::t_entry mem [SLOT_COUNT];
    rlp_pkg::t_entry r_rd;
    logic          w_hdone;
    logic [63:0]   w_hash;
    logic [IW-1:0] w_addr;
    logic          w_live, w_match;

    rlp_hash u_hash (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (s_axis_tvalid && s_axis_tready),
        .i_subject(s_axis_tdata[63:0]),
        .i_seq    (s_axis_tdata[127:64]),
        .o_done   (w_hdone),
        .o_hash   (w_hash)
    );

    assign s_axis_tready = (r_state == S_IDLE) && !r_out_v;
    assign w_addr = r_home + IW'(r_i);
    // Live test uses a 33-bit sum so the window never wraps.
    assign w_live  = ({1'b0, r_rd.epoch} + 33'(r_win)) >= {1'b0, r_now};
    assign w_match = (r_rd.subj == r_subj) && (r_rd.seq == r_seq) && w_live;

    always_ff @(posedge i_clk) begin
        if (r_state == S_CLEAR) mem[r_clr] <= '0;
        else if (r_state == S_WR) mem[r_slot] <= '{r_subj, r_seq, r_now};
        r_rd <= mem[w_addr];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: if (r_clr == IW'(SLOT_COUNT - 1)) n_state = S_IDLE;
            S_IDLE:  if (s_axis_tvalid && s_axis_tready) n_state = S_HASH;
            S_HASH:  if (w_hdone) n_state = S_RD;
            S_RD:    n_state = S_CHK;
            S_CHK: begin
                if (!r_pass) begin
                    if (w_match) n_state = S_OUT;
                    else n_state = S_RD;
                end else if (r_rd.epoch == '0 || !w_live ||
                             r_i == PW'(PROBE_LENGTH - 1)) begin
                    n_state = S_WR;
                end else begin
                    n_state = S_RD;
                end
            end
            S_WR:    n_state = S_OUT;
            S_OUT:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_win     <= rlp_pkg::WINDOW_RESET;
            r_acc_cnt <= '0;
            r_rej_cnt <= '0;
            r_ev_cnt  <= '0;
            r_out_v   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_win <= i_cfg_wdata;
            if (r_out_v && m_axis_tready) r_out_v <= 1'b0;
            case (r_state)
                S_CLEAR: r_clr <= r_clr + IW'(1);
                S_IDLE: begin
                    r_subj <= s_axis_tdata[63:0];
                    r_seq  <= s_axis_tdata[127:64];
                    r_now  <= s_axis_tdata[159:128];
                end
                S_HASH: begin
                    r_home    <= w_hash[IW-1:0];
                    r_i       <= '0;
                    r_pass    <= 1'b0;
                    r_verdict <= 1'b0;
                    r_evict   <= 1'b0;
                end
                S_CHK: begin
                    if (!r_pass) begin
                        if (w_match) begin
                            r_verdict <= 1'b1;
                            r_slot    <= w_addr;
                            r_rej_cnt <= r_rej_cnt + 32'd1;
                        end else if (r_i == PW'(PROBE_LENGTH - 1)) begin
                            r_pass <= 1'b1;
                            r_i    <= '0;
                        end else begin
                            r_i <= r_i + PW'(1);
                        end
                    end else if (r_rd.epoch == '0 || !w_live) begin
                        r_slot <= w_addr;
                    end else if (r_i == PW'(PROBE_LENGTH - 1)) begin
                        // Every probed slot is live: evict the home slot.
                        r_slot   <= r_home;
                        r_evict  <= 1'b1;
                        r_ev_cnt <= r_ev_cnt + 32'd1;
                    end else begin
                        r_i <= r_i + PW'(1);
                    end
                end
                S_WR: r_acc_cnt <= r_acc_cnt + 32'd1;
                S_OUT: r_out_v <= 1'b1;
                default: ;
            endcase
        end
    end

    logic [7:0] w_slot8;
    assign w_slot8 = 8'(r_slot);
    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata = {6'd0, r_ev_cnt, r_rej_cnt, r_acc_cnt, w_slot8,
                           r_evict, r_verdict};
endmodule
`default_nettype wire

FILE: dv/replay_ledger_probe_checker.sv
// Checker for the replay ledger probe: predicts each verdict beat and compares it.
`timescale 1ns / 100ps
module replay_ledger_probe_checker (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_we,
    input  wire logic [7:0]   i_cfg_wdata,
    input  wire logic         s_axis_tvalid,
    input  wire logic         s_axis_tready,
    input  wire logic [159:0] s_axis_tdata,
    input  wire logic         m_axis_tvalid,
    input  wire logic         m_axis_tready,
    input  wire logic [111:0] m_axis_tdata,
    output int                o_fail_count,
    output int                o_pending,
    output int                o_verdicts_seen,
    output int                o_replays_seen,
    output int                o_evictions_seen
);
    localparam int SLOTS = rlp_pkg::SLOT_COUNT_DEF;
    localparam int PROBES = rlp_pkg::PROBE_LENGTH_DEF;

    typedef struct packed {
        logic [31:0] evicted_total;
        logic [31:0] rejected_total;
        logic [31:0] accepted_total;
        logic [7:0]  slot_written;
        logic        evicted;
        logic        verdict;
    } t_verdict;

    logic [63:0] ledger_subj  [SLOTS];
    logic [63:0] ledger_seq   [SLOTS];
    logic [31:0] ledger_epoch [SLOTS];
    logic [31:0] n_accepted, n_rejected, n_evicted;
    logic [7:0]  window;
    t_verdict    verdicts_due[$];

    function automatic logic is_live(int k, logic [31:0] now);
        return ({1'b0, ledger_epoch[k]} + {25'd0, window}) >= {1'b0, now};
    endfunction

    // Walks the probe sequence exactly as the table logic should, updating the ledger.
    function automatic t_verdict predict_verdict(logic [159:0] req);
        logic [63:0] subj, seq, hsh;
        logic [31:0] now;
        int home, k, i;
        bit found;
        t_verdict v;
        subj = req[63:0];
        seq = req[127:64];
        now = req[159:128];
        hsh = subj * rlp_pkg::HASH_MULT + seq;
        home = int'(hsh[7:0]);
        v = '0;
        found = 0;
        for (i = 0; i < PROBES && !found; i++) begin
            k = (home + i) % SLOTS;
            if (ledger_subj[k] == subj && ledger_seq[k] == seq && is_live(k, now)) begin
                found = 1;
                v.verdict = 1'b1;
                v.slot_written = k[7:0];
            end
        end
        if (found) begin
            n_rejected++;
        end else begin
            for (i = 0; i < PROBES && !found; i++) begin
                k = (home + i) % SLOTS;
                if (ledger_epoch[k] == 0 || !is_live(k, now)) begin
                    found = 1;
                    v.slot_written = k[7:0];
                end
            end
            // Every probed slot is live, so the home entry gets pushed out.
            if (!found) begin
                k = home;
                v.slot_written = k[7:0];
                v.evicted = 1'b1;
                n_evicted++;
            end
            k = int'(v.slot_written);
            ledger_subj[k] = subj;
            ledger_seq[k] = seq;
            ledger_epoch[k] = now;
            n_accepted++;
        end
        v.accepted_total = n_accepted;
        v.rejected_total = n_rejected;
        v.evicted_total = n_evicted;
        return v;
    endfunction

    always @(posedge i_clk) begin
        t_verdict want, got;
        if (!i_rst_n) begin
            for (int k = 0; k < SLOTS; k++) begin
                ledger_subj[k] = '0;
                ledger_seq[k] = '0;
                ledger_epoch[k] = '0;
            end
            n_accepted = '0;
            n_rejected = '0;
            n_evicted = '0;
            window = rlp_pkg::WINDOW_RESET;
            verdicts_due.delete();
            o_fail_count = 0;
            o_verdicts_seen = 0;
            o_replays_seen = 0;
            o_evictions_seen = 0;
        end else begin
            if (i_cfg_we) window = i_cfg_wdata;
            if (m_axis_tvalid && m_axis_tready) begin
                got = t_verdict'(m_axis_tdata[105:0]);
                o_verdicts_seen++;
                if (got.verdict) o_replays_seen++;
                if (got.evicted) o_evictions_seen++;
                if (verdicts_due.size() == 0) begin
                    $display("%0t: unexpected verdict beat %h", $time, m_axis_tdata);
                    o_fail_count++;
                end else begin
                    want = verdicts_due.pop_front();
                    if (got !== want || m_axis_tdata[111:106] !== 6'd0) begin
                        $display("%0t: verdict mismatch expected %h actual %h",
                                 $time, want, m_axis_tdata);
                        o_fail_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                verdicts_due.push_back(predict_verdict(s_axis_tdata));
        end
        o_pending = verdicts_due.size();
    end
endmodule

FILE: dv/tb_replay_ledger_probe_unit.sv
// Testbench top for the replay ledger probe: stimulus, idling phases and the verdict.
`timescale 1ns / 100ps
module tb_replay_ledger_probe_unit;
    localparam int WATCHDOG_LIMIT = 5000;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_we;
    logic [7:0]   i_cfg_wdata;
    logic         s_axis_tvalid;
    wire logic    s_axis_tready;
    logic [159:0] s_axis_tdata;
    wire logic    m_axis_tvalid;
    logic         m_axis_tready;
    wire [111:0]  m_axis_tdata;

    int fail_count, pending, verdicts_seen, replays_seen, evictions_seen;
    int send_idle_pct, recv_stall_pct;
    bit hold_off;
    int idle_cycles;

    // Recently offered requests, replayed later to provoke replay verdicts.
    logic [63:0] past_subj[$];
    logic [63:0] past_seq[$];
    logic [31:0] epoch_now;

    replay_ledger_probe_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    replay_ledger_probe_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .o_fail_count(fail_count), .o_pending(pending),
        .o_verdicts_seen(verdicts_seen), .o_replays_seen(replays_seen),
        .o_evictions_seen(evictions_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // The receiver stalls at the phase's rate, or holds off entirely when asked.
    always @(negedge i_clk) begin
        if (!i_rst_n || hold_off)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // A watchdog that ends the run if no beat moves for too long. The deliberate
    // hold-off is far shorter than the limit.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog expired with %0d verdicts pending", $time, pending);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Offers one request beat and waits until it is taken. The request lines are
    // set with blocking assignments so that back-to-back beats never stack two
    // updates of tvalid in one falling edge.
    task automatic send_request(input logic [63:0] subj, input logic [63:0] seq,
                                input logic [31:0] now);
        while ($urandom_range(99) < send_idle_pct) @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata = {now, seq, subj};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        past_subj.push_back(subj);
        past_seq.push_back(seq);
        if (past_subj.size() > 40) begin
            void'(past_subj.pop_front());
            void'(past_seq.pop_front());
        end
    endtask

    // Waits until every verdict is in, then lets the block settle before a write.
    task automatic drain_and_set_window(input logic [7:0] w);
        while (pending != 0) @(negedge i_clk);
        repeat (50) @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= w;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Mostly fresh pairs, many of them on subject zero, with frequent repeats and
    // collisions on a few home slots so that probe chains fill and evictions occur.
    task automatic random_requests(input int count);
        logic [63:0] subj, seq;
        int pick, r;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(99);
            if (r < 30 && past_subj.size() != 0) begin
                pick = $urandom_range(past_subj.size() - 1);
                subj = past_subj[pick];
                seq = past_seq[pick];
            end else if (r < 55) begin
                // Subject 0 puts the home slot at the low byte of seq.
                subj = 64'd0;
                seq = {$urandom(), $urandom()};
                seq[7:0] = 8'($urandom_range(3));
            end else if (r < 65) begin
                subj = 64'd0;
                seq = 64'd0;
            end else begin
                subj = {$urandom(), $urandom()};
                seq = {$urandom(), $urandom()};
            end
            if ($urandom_range(9) == 0) epoch_now = $urandom();
            else if ($urandom_range(3) == 0) epoch_now = epoch_now + $urandom_range(4);
            send_request(subj, seq, ($urandom_range(19) == 0) ? 32'd0 : epoch_now);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        hold_off = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        epoch_now = 32'd100;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part with the reset window of two epochs.
        send_request(64'd0, 64'd0, 32'd1);            // empty slot looks like a live match
        send_request(64'd0, 64'd0, 32'd3);            // same pair beyond the window
        send_request(64'd5, 64'd7, 32'd0);            // recorded at epoch zero, reads empty
        send_request(64'd5, 64'd7, 32'd0);
        send_request('1, '1, '1);                     // all fields at their maximum
        send_request('1, '1, '1);                     // exact replay
        send_request(64'd5, 64'd7, 32'd10);
        send_request(64'd5, 64'd7, 32'd12);           // live at the window edge
        send_request(64'd5, 64'd7, 32'd13);           // just stale
        // Ten distinct pairs on one home slot fill the chain and force evictions.
        for (int k = 1; k <= 10; k++)
            send_request(64'd0, {56'(k), 8'd200}, 32'd50);
        send_request(64'hAAAA_5555_AAAA_5555, 64'h5555_AAAA_5555_AAAA, 32'h8000_0000);

        drain_and_set_window(8'd0);
        send_request(64'd9, 64'd9, 32'd20);
        send_request(64'd9, 64'd9, 32'd20);           // window zero still matches same epoch
        send_request(64'd9, 64'd9, 32'd21);
        drain_and_set_window(8'd255);
        send_request(64'd9, 64'd9, 32'd276);          // epoch sum exceeds 255 without wrap
        send_request(64'd1, 64'd1, 32'hFFFF_FFFF);

        // Random phases: no idling, sender idle, receiver stalls, both.
        send_idle_pct = 0;  recv_stall_pct = 0;  random_requests(200);
        drain_and_set_window(8'd3);
        send_idle_pct = 60; recv_stall_pct = 0;  random_requests(200);
        drain_and_set_window(8'd1);
        send_idle_pct = 0;  recv_stall_pct = 60; random_requests(200);

        // Long receiver hold-off while requests keep coming, filling the block.
        fork
            begin
                hold_off = 1'b1;
                repeat (400) @(negedge i_clk);
                hold_off = 1'b0;
            end
            random_requests(20);
        join
        drain_and_set_window(8'd255);
        send_idle_pct = 13; recv_stall_pct = 13; random_requests(120);
        drain_and_set_window(8'd2);
        random_requests(90);

        while (pending != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
        $display("Covered %0d verdicts: %0d replays, %0d forced evictions,", verdicts_seen,
                 replays_seen, evictions_seen);
        $display("over windows 0 to 255 with idle, stalled and held-off receivers.");
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

FILE: replay_ledger_probe_unit.f
rtl/rlp_pkg.sv
rtl/rlp_hash.sv
rtl/replay_ledger_probe_unit.sv
dv/replay_ledger_probe_checker.sv
dv/tb_replay_ledger_probe_unit.sv
